[rtl/core/llas_pkg.sv]
// Shared types and constants of the life-like automaton step core.
// Used by the controller, the datapath, the interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none

package llas_pkg;

	// Fixed field widths of the channels
	localparam int unsigned REQ_W     = 2;
	localparam int unsigned ROW_IDX_W = 6;
	localparam int unsigned ROW_W     = 64;
	localparam int unsigned CFG_W     = 4;
	localparam int unsigned CFG_IDX_W = 1;

	// Request codes
	typedef enum logic [REQ_W-1:0] {
		REQ_LOAD    = 2'd0,
		REQ_ADVANCE = 2'd1,
		REQ_EMIT    = 2'd2,
		REQ_NONE    = 2'd3
	} llas_req_t;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BIRTH   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SURVIVE = 1'b1;

	// Configuration reset values
	localparam logic [CFG_W-1:0] BIRTH_RST   = 4'd3;
	localparam logic [CFG_W-1:0] SURVIVE_RST = 4'd2;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_PRIME = 2'd1,
		ST_FILL  = 2'd2,
		ST_ROW   = 2'd3
	} llas_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load_wr;    // write the input row into the grid
		logic prime;      // read row 0
		logic fill;       // capture row 0, read row 1
		logic step;       // emit current row, shift the window
		logic write_back; // store the next generation of the current row
	} llas_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic out_free;   // output register can take a row this cycle
		logic last_row;   // row counter is on the final row
	} llas_stat_t;

endpackage

`default_nettype wire

[rtl/core/llas_if.sv]
// Valid/ready channel interfaces for request items and row result items.
// Depends on llas_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface llas_in_if;
	logic                            valid;
	logic                            ready;
	logic [llas_pkg::REQ_W-1:0]      req_type;
	logic [llas_pkg::ROW_IDX_W-1:0]  row_index;
	logic [llas_pkg::ROW_W-1:0]      row_bits;

	modport source (output valid, req_type, row_index, row_bits, input ready);
	modport sink   (input valid, req_type, row_index, row_bits, output ready);
endinterface

interface llas_out_if;
	logic                            valid;
	logic                            ready;
	logic [llas_pkg::ROW_IDX_W-1:0]  out_row_index;
	logic [llas_pkg::ROW_W-1:0]      out_row_bits;
	logic                            last_row;

	modport source (output valid, out_row_index, out_row_bits, last_row, input ready);
	modport sink   (input valid, out_row_index, out_row_bits, last_row, output ready);
endinterface

`default_nettype wire

[rtl/core/llas_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module llas_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port, hold data when idle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/core/llas_ctrl.sv]
// Controller of the automaton core: sequences loads, grid sweeps and readouts.
// Depends on llas_pkg for the state, command and status types.
`timescale 1ns / 1ps
`default_nettype none

module llas_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	input  wire logic [llas_pkg::REQ_W-1:0] req_type,
	input  wire llas_pkg::llas_stat_t       stat,
	output      logic                       in_ready,
	output      llas_pkg::llas_cmd_t        cmd
);

	llas_pkg::llas_state_t state_q, state_d;
	logic                  adv_q;
	logic                  accept;

	assign accept = in_valid && (state_q == llas_pkg::ST_IDLE);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			llas_pkg::ST_IDLE: begin
				if (in_valid && (req_type inside {llas_pkg::REQ_ADVANCE,
						llas_pkg::REQ_EMIT})) begin
					state_d = llas_pkg::ST_PRIME;
				end
			end
			llas_pkg::ST_PRIME: state_d = llas_pkg::ST_FILL;
			llas_pkg::ST_FILL:  state_d = llas_pkg::ST_ROW;
			llas_pkg::ST_ROW: begin
				if (stat.out_free && stat.last_row) begin
					state_d = llas_pkg::ST_IDLE;
				end
			end
			default: state_d = llas_pkg::ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_ready       = (state_q == llas_pkg::ST_IDLE);
		cmd.load_wr    = accept && (req_type == llas_pkg::REQ_LOAD);
		cmd.prime      = (state_q == llas_pkg::ST_PRIME);
		cmd.fill       = (state_q == llas_pkg::ST_FILL);
		cmd.step       = (state_q == llas_pkg::ST_ROW) && stat.out_free;
		cmd.write_back = (state_q == llas_pkg::ST_ROW) && stat.out_free && adv_q;
	end

	// State and sweep mode registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= llas_pkg::ST_IDLE;
			adv_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				adv_q <= (req_type == llas_pkg::REQ_ADVANCE);
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/llas_dp.sv]
// Datapath of the automaton core: grid RAM with row valid bits, three-row
// window, per-row cell update, configuration and output registers.
// Depends on llas_pkg and llas_ram.
`timescale 1ns / 1ps
`default_nettype none

module llas_dp #(
	parameter int unsigned GRID_ROWS = 64,
	parameter int unsigned GRID_COLS = 64
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire llas_pkg::llas_cmd_t                 cmd,
	output      llas_pkg::llas_stat_t                stat,
	input  wire logic                                cfg_we,
	input  wire logic [llas_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [llas_pkg::CFG_W-1:0]          cfg_data,
	input  wire logic [llas_pkg::ROW_IDX_W-1:0]      row_index,
	input  wire logic [llas_pkg::ROW_W-1:0]          row_bits,
	output      logic                                out_valid,
	input  wire logic                                out_ready,
	output      logic [llas_pkg::ROW_IDX_W-1:0]      out_row_index,
	output      logic [llas_pkg::ROW_W-1:0]          out_row_bits,
	output      logic                                last_row
);

	localparam int unsigned AW = $clog2(GRID_ROWS);

	logic [llas_pkg::CFG_W-1:0] birth_q, survive_q;
	logic [GRID_ROWS-1:0]       row_ok_q;
	logic                       rd_ok_q;
	logic [AW-1:0]              row_q;
	logic [GRID_COLS-1:0]       above_q, cur_q;
	logic                       out_valid_q;
	logic [AW-1:0]              out_idx_q;
	logic [GRID_COLS-1:0]       out_bits_q;
	logic                       out_last_q;

	logic                       ram_we;
	logic [AW-1:0]              ram_waddr;
	logic [GRID_COLS-1:0]       ram_wdata;
	logic                       ram_re;
	logic [AW-1:0]              ram_raddr;
	logic [GRID_COLS-1:0]       ram_rdata;
	logic [GRID_COLS-1:0]       rd_row;
	logic [GRID_COLS-1:0]       below;
	logic [GRID_COLS-1:0]       next_row;
	logic [AW:0]                ahead;
	logic                       ahead_ok;
	logic                       load_ok;
	logic                       is_last;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			birth_q   <= llas_pkg::BIRTH_RST;
			survive_q <= llas_pkg::SURVIVE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				llas_pkg::CFG_BIRTH:   birth_q   <= cfg_data;
				llas_pkg::CFG_SURVIVE: survive_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign is_last  = (row_q == AW'(GRID_ROWS - 1));
	assign ahead    = {1'b0, row_q} + (AW + 1)'(2);
	assign ahead_ok = (ahead < (AW + 1)'(GRID_ROWS));
	assign load_ok  = ({1'b0, row_index} < (llas_pkg::ROW_IDX_W + 1)'(GRID_ROWS));

	// Grid RAM port selection
	always_comb begin
		ram_we    = (cmd.load_wr && load_ok) || cmd.write_back;
		ram_waddr = cmd.write_back ? row_q : row_index[AW-1:0];
		ram_wdata = cmd.write_back ? next_row : row_bits[GRID_COLS-1:0];
		ram_re    = cmd.prime || cmd.fill || (cmd.step && ahead_ok);
		if (cmd.prime) begin
			ram_raddr = '0;
		end else if (cmd.fill) begin
			ram_raddr = AW'(1);
		end else begin
			ram_raddr = ahead[AW-1:0];
		end
	end

	llas_ram #(
		.WIDTH (GRID_COLS),
		.DEPTH (GRID_ROWS)
	) u_grid (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Row valid bits: a row never written reads as all dead
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_ok_q <= '0;
			rd_ok_q  <= 1'b0;
		end else begin
			if (ram_we) begin
				row_ok_q[ram_waddr] <= 1'b1;
			end
			if (ram_re) begin
				rd_ok_q <= row_ok_q[ram_raddr];
			end
		end
	end

	assign rd_row = rd_ok_q ? ram_rdata : '0;
	assign below  = is_last ? '0 : rd_row;

	// Next generation of the current row, dead cells past both edges
	always_comb begin
		logic [GRID_COLS+1:0] a_ext, c_ext, b_ext;
		logic [3:0]           cnt;
		a_ext = {1'b0, above_q, 1'b0};
		c_ext = {1'b0, cur_q, 1'b0};
		b_ext = {1'b0, below, 1'b0};
		for (int j = 0; j < GRID_COLS; j++) begin
			cnt = 4'(a_ext[j]) + 4'(a_ext[j+1]) + 4'(a_ext[j+2])
				+ 4'(c_ext[j]) + 4'(c_ext[j+2])
				+ 4'(b_ext[j]) + 4'(b_ext[j+1]) + 4'(b_ext[j+2]);
			if (cur_q[j]) begin
				next_row[j] = (cnt >= survive_q) && (cnt <= birth_q);
			end else begin
				next_row[j] = (cnt == birth_q);
			end
		end
	end

	// Row window: old copies of the row above and the current row
	always_ff @(posedge clk) begin
		if (cmd.fill) begin
			above_q <= '0;
			cur_q   <= rd_row;
		end else if (cmd.step) begin
			above_q <= cur_q;
			cur_q   <= below;
		end
	end

	// Row counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (cmd.fill) begin
			row_q <= '0;
		end else if (cmd.step) begin
			row_q <= row_q + AW'(1);
		end
	end

	// Output register: load on step, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			out_idx_q  <= row_q;
			out_bits_q <= cmd.write_back ? next_row : cur_q;
			out_last_q <= is_last;
		end
	end

	assign stat.out_free  = !out_valid_q || out_ready;
	assign stat.last_row  = is_last;

	assign out_valid      = out_valid_q;
	assign out_row_index  = llas_pkg::ROW_IDX_W'(out_idx_q);
	assign out_row_bits   = llas_pkg::ROW_W'(out_bits_q);
	assign last_row       = out_last_q;

endmodule

`default_nettype wire

[rtl/core/life_like_automaton_step_core.sv]
// Top level of the life-like automaton step core: controller plus datapath.
// Depends on llas_pkg, llas_if, llas_ctrl and llas_dp.
//
// Channel  Dir  Handshake      Payload
// in_ch    in   valid/ready    req_type, row_index, row_bits
// out_ch   out  valid/ready    out_row_index, out_row_bits, last_row
// cfg      in   cfg_we         cfg_index, cfg_data (0 birth, 1 survive low)
//
// A load is written to the grid RAM as it is accepted. A generation or readout
// runs from its accepting cycle through ST_PRIME and ST_FILL, which fill the
// row window from the grid RAM, then one row per cycle while the output is not
// stalled, through the single RAM read port, before the next accept.
// Reset clears the grid through per-row valid bits, so no clearing pass runs.
// A stalled output stops the row sweep; the finished last row may wait in
// the output register while the next item is accepted.
`timescale 1ns / 1ps
`default_nettype none

module life_like_automaton_step_core #(
	parameter int unsigned GRID_ROWS = 64,
	parameter int unsigned GRID_COLS = 64
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	llas_in_if.sink                                in_ch,
	llas_out_if.source                             out_ch,
	input  wire logic                              cfg_we,
	input  wire logic [llas_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [llas_pkg::CFG_W-1:0]        cfg_data
);

	llas_pkg::llas_cmd_t  cmd;
	llas_pkg::llas_stat_t stat;
	logic                 in_ready;

	assign in_ch.ready = in_ready;

	// Sequence control
	llas_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.req_type (in_ch.req_type),
		.stat     (stat),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	// Grid storage and cell update
	llas_dp #(
		.GRID_ROWS (GRID_ROWS),
		.GRID_COLS (GRID_COLS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.row_index     (in_ch.row_index),
		.row_bits      (in_ch.row_bits),
		.out_valid     (out_ch.valid),
		.out_ready     (out_ch.ready),
		.out_row_index (out_ch.out_row_index),
		.out_row_bits  (out_ch.out_row_bits),
		.last_row      (out_ch.last_row)
	);

endmodule

`default_nettype wire

[rtl/core/llas_checker.sv]
// Port-level checks of the automaton core, bound to the top level.
// Depends on llas_pkg for field widths and request codes.
`timescale 1ns / 1ps
`default_nettype none

module llas_checker #(
	parameter int unsigned GRID_ROWS = 64
) (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             in_valid,
	input wire logic                             in_ready,
	input wire logic [llas_pkg::REQ_W-1:0]       req_type,
	input wire logic                             out_valid,
	input wire logic                             out_ready,
	input wire logic [llas_pkg::ROW_IDX_W-1:0]   out_row_index,
	input wire logic [llas_pkg::ROW_W-1:0]       out_row_bits,
	input wire logic                             last_row
);

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	// Stalled result item holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_row_bits)
			&& $stable(out_row_index) && $stable(last_row))
		else $error("stalled output item changed");

	// A grid request blocks new items on the next cycle
	a_sweep_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (req_type == llas_pkg::REQ_ADVANCE || req_type == llas_pkg::REQ_EMIT)
			|=> !in_ready)
		else $error("input ready during grid sweep");

	// A load leaves the block ready for the next item
	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && req_type == llas_pkg::REQ_LOAD |=> in_ready)
		else $error("input not ready after load");

	// Last row mark sits exactly on the final row index
	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_row == (out_row_index == llas_pkg::ROW_IDX_W'(GRID_ROWS - 1))))
		else $error("last row mark misplaced");

endmodule

bind life_like_automaton_step_core llas_checker #(
	.GRID_ROWS (GRID_ROWS)
) u_llas_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_ch.valid),
	.in_ready      (in_ch.ready),
	.req_type      (in_ch.req_type),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.out_row_index (out_ch.out_row_index),
	.out_row_bits  (out_ch.out_row_bits),
	.last_row      (out_ch.last_row)
);

`default_nettype wire
